>>> rtl/lbe_pkg.sv
// shared types, constants and the bond candidate table of the lattice bond enumerator
package lbe_pkg;

  localparam int MAX_SITES   = 1024;
  localparam int SITE_W      = $clog2(MAX_SITES);
  localparam int MAX_BONDS   = 4096;
  localparam int SEEN_AW     = $clog2(MAX_BONDS);
  localparam int SEEN_CW     = SEEN_AW + 1;
  localparam int COORD_W     = 11;
  localparam int SIZE_W      = 11;
  localparam int MUL_A_W     = 2 * COORD_W;
  localparam int MUL_P_W     = MUL_A_W + SIZE_W;
  localparam int ACC_W       = 36;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam logic [2:0] K_LAST = 3'd5;

  // lattice kinds
  localparam logic [2:0] KIND_SQUARE = 3'd0;
  localparam logic [2:0] KIND_TRI    = 3'd1;
  localparam logic [2:0] KIND_HONEY  = 3'd2;
  localparam logic [2:0] KIND_KAGOME = 3'd3;
  localparam logic [2:0] KIND_PYRO   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_KIND     = 3'd0;
  localparam logic [2:0] CFG_SIZE_X   = 3'd1;
  localparam logic [2:0] CFG_SIZE_Y   = 3'd2;
  localparam logic [2:0] CFG_SIZE_Z   = 3'd3;
  localparam logic [2:0] CFG_PERIODIC = 3'd4;

  // neighbor offset codes
  localparam logic [1:0] D_ZERO  = 2'b00;
  localparam logic [1:0] D_PLUS  = 2'b01;
  localparam logic [1:0] D_MINUS = 2'b11;

  // honeycomb colours
  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;

  typedef struct packed {
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic [9:0] cell_z;
    logic       pass_select;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [SITE_W-1:0] site_low;
    logic [SITE_W-1:0] site_high;
    logic [1:0]        bond_colour;
    logic              last_of_cell;
  } out_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic              periodic;
  } cfg_t;

  typedef enum logic [1:0] {ENT_CLEAR, ENT_BOND, ENT_END} entry_kind_t;

  typedef struct packed {
    entry_kind_t       kind;
    logic [SITE_W-1:0] lo;
    logic [SITE_W-1:0] hi;
    logic [1:0]        colour;
  } entry_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sa;
    logic [1:0] sb;
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
    logic [1:0] colour;
    logic       sq;
  } cand_t;

  typedef enum logic [3:0] {
    F_IDLE, F_CLEAR, F_CAND, F_MUL1, F_ADD1, F_MUL2, F_ADD2, F_FIN, F_PUSH, F_END
  } front_state_t;

  typedef enum logic [2:0] {B_IDLE, B_SCAN, B_NEW, B_EMIT, B_LAST} back_state_t;

  // candidate bond k of a cell: endpoint a is the cell itself, b sits at the offset
  function automatic cand_t cand_info(input logic [2:0] kind, input logic pass,
                                      input logic [2:0] k);
    cand_t c;
    c = '0;
    case (kind)
      KIND_SQUARE: begin
        if (k == 3'd0) begin
          c.en = 1'b1; c.dx = D_PLUS; c.sq = 1'b1;
        end else if (k == 3'd1) begin
          c.en = 1'b1; c.dy = D_PLUS; c.sq = 1'b1;
        end
      end
      KIND_TRI: begin
        case (k)
          3'd0: begin c.en = 1'b1; c.dx = D_PLUS; end
          3'd1: begin c.en = 1'b1; c.dy = D_PLUS; end
          3'd2: begin c.en = 1'b1; c.dx = D_MINUS; c.dy = D_PLUS; end
          default: c.en = 1'b0;
        endcase
      end
      KIND_HONEY: begin
        case (k)
          3'd0: begin c.en = 1'b1; c.sb = 2'd1; c.colour = COL_Z; end
          3'd1: begin c.en = 1'b1; c.sb = 2'd1; c.dx = D_MINUS; c.colour = COL_X; end
          3'd2: begin c.en = 1'b1; c.sb = 2'd1; c.dy = D_MINUS; c.colour = COL_Y; end
          default: c.en = 1'b0;
        endcase
      end
      KIND_KAGOME: begin
        c.en = 1'b1;
        case (k)
          3'd0: begin c.sa = 2'd0; c.sb = 2'd1; end
          3'd1: begin c.sa = 2'd0; c.sb = 2'd2; end
          3'd2: begin c.sa = 2'd1; c.sb = 2'd2; end
          3'd3: begin c.sa = 2'd1; c.sb = 2'd0; c.dx = D_PLUS; end
          3'd4: begin c.sa = 2'd2; c.sb = 2'd0; c.dy = D_PLUS; end
          3'd5: begin c.sa = 2'd2; c.sb = 2'd1; c.dx = D_MINUS; c.dy = D_PLUS; end
          default: c.en = 1'b0;
        endcase
      end
      KIND_PYRO: begin
        c.en = 1'b1;
        if (!pass) begin
          case (k)
            3'd0: begin c.sa = 2'd0; c.sb = 2'd1; end
            3'd1: begin c.sa = 2'd0; c.sb = 2'd2; end
            3'd2: begin c.sa = 2'd0; c.sb = 2'd3; end
            3'd3: begin c.sa = 2'd1; c.sb = 2'd2; end
            3'd4: begin c.sa = 2'd1; c.sb = 2'd3; end
            3'd5: begin c.sa = 2'd2; c.sb = 2'd3; end
            default: c.en = 1'b0;
          endcase
        end else begin
          case (k)
            3'd0: begin c.sa = 2'd0; c.sb = 2'd1; c.dx = D_MINUS; end
            3'd1: begin c.sa = 2'd0; c.sb = 2'd2; c.dy = D_MINUS; end
            3'd2: begin c.sa = 2'd0; c.sb = 2'd3; c.dz = D_MINUS; end
            3'd3: begin c.sa = 2'd1; c.sb = 2'd2; c.dy = D_MINUS; c.dz = D_PLUS; end
            3'd4: begin c.sa = 2'd1; c.sb = 2'd3; end
            3'd5: begin c.sa = 2'd2; c.sb = 2'd3; end
            default: c.en = 1'b0;
          endcase
        end
      end
      default: c.en = 1'b0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/lbe_front.sv
// front end: accepts cells, walks the candidate bonds and computes site indices
module lbe_front (
  input  logic                clk,
  input  logic                rst,
  input  lbe_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  lbe_pkg::in_t        in_data,
  output logic                push,
  output lbe_pkg::entry_t     push_data,
  input  logic                full
);

  lbe_pkg::front_state_t state, state_next;

  logic [lbe_pkg::COORD_W-1:0] cx, cy, cz;
  logic [lbe_pkg::COORD_W-1:0] nbx, nby, nbz;
  logic [lbe_pkg::COORD_W-1:0] px, py, pz;
  logic [1:0]                  psub, sb, colour;
  logic                        pass_r, bad_r, phase;
  logic [2:0]                  k;
  logic [lbe_pkg::ACC_W-1:0]   acc, site_a, site_b, site;

  logic                          is3d, bad_in, usable, drop;
  lbe_pkg::cand_t                cand;
  logic [lbe_pkg::COORD_W:0]     wx, wy, wz;
  logic [lbe_pkg::MUL_A_W-1:0]   mul_a;
  logic [lbe_pkg::SIZE_W-1:0]    mul_b;
  logic [lbe_pkg::MUL_P_W-1:0]   prod;
  logic [lbe_pkg::ACC_W-1:0]     lo_full, hi_full;

  // one neighbor coordinate: {ok, value}
  function automatic logic [lbe_pkg::COORD_W:0] step_coord(
      input logic [lbe_pkg::COORD_W-1:0] v, input logic [1:0] d,
      input logic [lbe_pkg::SIZE_W-1:0] len, input logic wrap, input logic sq);
    logic [lbe_pkg::COORD_W:0] up;
    logic [lbe_pkg::COORD_W:0] r;
    up = {1'b0, v} + 1'b1;
    case (d)
      lbe_pkg::D_PLUS: begin
        if (up < {1'b0, len}) r = {1'b1, up[lbe_pkg::COORD_W-1:0]};
        else if (wrap && (!sq || len > lbe_pkg::SIZE_W'(2))) r = {1'b1, {lbe_pkg::COORD_W{1'b0}}};
        else r = '0;
      end
      lbe_pkg::D_MINUS: begin
        if (v != '0) r = {1'b1, v - 1'b1};
        else if (wrap) r = {1'b1, len - 1'b1};
        else r = '0;
      end
      default: r = {1'b1, v};
    endcase
    return r;
  endfunction

  assign is3d = (cfg.kind == lbe_pkg::KIND_PYRO);

  // cell range, kind and pass checks
  assign bad_in = ({1'b0, in_data.cell_x} >= cfg.size_x) ||
                  ({1'b0, in_data.cell_y} >= cfg.size_y) ||
                  (is3d && ({1'b0, in_data.cell_z} >= cfg.size_z)) ||
                  (cfg.kind > lbe_pkg::KIND_PYRO) ||
                  ((cfg.kind < lbe_pkg::KIND_PYRO) && in_data.pass_select);

  // candidate lookup and neighbor coordinates
  assign cand   = lbe_pkg::cand_info(cfg.kind, pass_r, k);
  assign wx     = step_coord(cx, cand.dx, cfg.size_x, cfg.periodic, cand.sq);
  assign wy     = step_coord(cy, cand.dy, cfg.size_y, cfg.periodic, cand.sq);
  assign wz     = step_coord(cz, cand.dz, cfg.size_z, cfg.periodic, cand.sq);
  assign usable = cand.en && wx[lbe_pkg::COORD_W] && wy[lbe_pkg::COORD_W] &&
                  wz[lbe_pkg::COORD_W];

  // shared multiplier
  always_comb begin
    if (state == lbe_pkg::F_MUL2) begin
      mul_a = acc[lbe_pkg::MUL_A_W-1:0];
      mul_b = cfg.size_z;
    end else begin
      mul_a = lbe_pkg::MUL_A_W'(is3d ? px : py);
      mul_b = is3d ? cfg.size_y : cfg.size_x;
    end
  end
  assign prod = lbe_pkg::MUL_P_W'(mul_a) * lbe_pkg::MUL_P_W'(mul_b);

  // final site index from the cell base
  always_comb begin
    case (cfg.kind)
      lbe_pkg::KIND_HONEY:  site = (acc << 1) + lbe_pkg::ACC_W'(psub);
      lbe_pkg::KIND_KAGOME: site = (acc << 1) + acc + lbe_pkg::ACC_W'(psub);
      lbe_pkg::KIND_PYRO:   site = (acc << 2) + lbe_pkg::ACC_W'(psub);
      default:              site = acc;
    endcase
  end

  // ordered pair and drop checks
  assign lo_full = (site_a < site_b) ? site_a : site_b;
  assign hi_full = (site_a < site_b) ? site_b : site_a;
  assign drop    = (site_a == site_b) || (hi_full >= lbe_pkg::ACC_W'(lbe_pkg::MAX_SITES));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lbe_pkg::F_IDLE:
        if (in_valid) begin
          if (in_data.restart) state_next = lbe_pkg::F_CLEAR;
          else if (bad_in)     state_next = lbe_pkg::F_END;
          else                 state_next = lbe_pkg::F_CAND;
        end
      lbe_pkg::F_CLEAR:
        if (!full) state_next = bad_r ? lbe_pkg::F_END : lbe_pkg::F_CAND;
      lbe_pkg::F_CAND:
        if (usable)             state_next = lbe_pkg::F_MUL1;
        else if (k == lbe_pkg::K_LAST) state_next = lbe_pkg::F_END;
      lbe_pkg::F_MUL1: state_next = lbe_pkg::F_ADD1;
      lbe_pkg::F_ADD1: state_next = is3d ? lbe_pkg::F_MUL2 : lbe_pkg::F_FIN;
      lbe_pkg::F_MUL2: state_next = lbe_pkg::F_ADD2;
      lbe_pkg::F_ADD2: state_next = lbe_pkg::F_FIN;
      lbe_pkg::F_FIN:  state_next = phase ? lbe_pkg::F_PUSH : lbe_pkg::F_MUL1;
      lbe_pkg::F_PUSH:
        if (drop || !full) state_next = (k == lbe_pkg::K_LAST) ? lbe_pkg::F_END : lbe_pkg::F_CAND;
      lbe_pkg::F_END:
        if (!full) state_next = lbe_pkg::F_IDLE;
      default: state_next = lbe_pkg::F_IDLE;
    endcase
  end

  // handshake and queue outputs
  always_comb begin
    in_ready         = (state == lbe_pkg::F_IDLE) && !rst;
    push             = 1'b0;
    push_data.kind   = lbe_pkg::ENT_BOND;
    push_data.lo     = lo_full[lbe_pkg::SITE_W-1:0];
    push_data.hi     = hi_full[lbe_pkg::SITE_W-1:0];
    push_data.colour = colour;
    case (state)
      lbe_pkg::F_CLEAR: begin
        push           = !full;
        push_data.kind = lbe_pkg::ENT_CLEAR;
      end
      lbe_pkg::F_PUSH: push = !full && !drop;
      lbe_pkg::F_END: begin
        push           = !full;
        push_data.kind = lbe_pkg::ENT_END;
      end
      default: push = 1'b0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= lbe_pkg::F_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      lbe_pkg::F_IDLE: begin
        cx        <= lbe_pkg::COORD_W'(in_data.cell_x);
        cy        <= lbe_pkg::COORD_W'(in_data.cell_y);
        cz        <= is3d ? lbe_pkg::COORD_W'(in_data.cell_z) : '0;
        pass_r    <= in_data.pass_select;
        bad_r     <= bad_in;
        k         <= '0;
      end
      lbe_pkg::F_CAND: begin
        nbx    <= wx[lbe_pkg::COORD_W-1:0];
        nby    <= wy[lbe_pkg::COORD_W-1:0];
        nbz    <= wz[lbe_pkg::COORD_W-1:0];
        sb     <= cand.sb;
        colour <= cand.colour;
        px     <= cx;
        py     <= cy;
        pz     <= cz;
        psub   <= cand.sa;
        phase  <= 1'b0;
        if (!usable) k <= k + 1'b1;
      end
      lbe_pkg::F_MUL1: acc <= lbe_pkg::ACC_W'(prod);
      lbe_pkg::F_ADD1: acc <= acc + lbe_pkg::ACC_W'(is3d ? py : px);
      lbe_pkg::F_MUL2: acc <= lbe_pkg::ACC_W'(prod);
      lbe_pkg::F_ADD2: acc <= acc + lbe_pkg::ACC_W'(pz);
      lbe_pkg::F_FIN: begin
        if (!phase) begin
          site_a <= site;
          px     <= nbx;
          py     <= nby;
          pz     <= nbz;
          psub   <= sb;
          phase  <= 1'b1;
        end else begin
          site_b <= site;
        end
      end
      lbe_pkg::F_PUSH:
        if (drop || !full) k <= k + 1'b1;
      default: k <= k;
    endcase
  end

endmodule

>>> rtl/lbe_queue.sv
// short queue of bond entries between the front and back ends
module lbe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lbe_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output lbe_pkg::entry_t head
);

  lbe_pkg::entry_t              slots [lbe_pkg::QUEUE_DEPTH];
  logic [lbe_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [lbe_pkg::QUEUE_AW:0]   fill;

  assign full  = (fill == (lbe_pkg::QUEUE_AW+1)'(lbe_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> rtl/lbe_back.sv
// back end: seen-store lookup and insert, result hold and output register
module lbe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  lbe_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lbe_pkg::out_t   out_data
);

  lbe_pkg::back_state_t state, state_next;

  logic [2*lbe_pkg::SITE_W-1:0]  seen_mem [lbe_pkg::MAX_BONDS];
  logic [2*lbe_pkg::SITE_W-1:0]  rd_data;
  logic [lbe_pkg::SEEN_CW-1:0]   count, idx;
  logic                          rd_v;
  logic [lbe_pkg::SITE_W-1:0]    cur_lo, cur_hi, hold_lo, hold_hi;
  logic [1:0]                    cur_colour, hold_colour;
  logic                          hold_valid;

  logic rd_issue, match, wr_en, out_free;

  assign out_free = !out_valid || out_ready;
  assign match    = rd_v && (rd_data == {cur_lo, cur_hi});

  // control outputs
  always_comb begin
    pop      = (state == lbe_pkg::B_IDLE) && !empty;
    rd_issue = (state == lbe_pkg::B_SCAN) && (idx < count) && !match;
    wr_en    = (state == lbe_pkg::B_NEW) &&
               (count < lbe_pkg::SEEN_CW'(lbe_pkg::MAX_BONDS));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lbe_pkg::B_IDLE:
        if (!empty) begin
          case (head.kind)
            lbe_pkg::ENT_BOND: state_next = lbe_pkg::B_SCAN;
            lbe_pkg::ENT_END:  state_next = hold_valid ? lbe_pkg::B_LAST : lbe_pkg::B_IDLE;
            default:           state_next = lbe_pkg::B_IDLE;
          endcase
        end
      lbe_pkg::B_SCAN:
        if (match)                        state_next = lbe_pkg::B_IDLE;
        else if (idx >= count && !rd_v)   state_next = lbe_pkg::B_NEW;
      lbe_pkg::B_NEW:  state_next = hold_valid ? lbe_pkg::B_EMIT : lbe_pkg::B_IDLE;
      lbe_pkg::B_EMIT: if (out_free) state_next = lbe_pkg::B_IDLE;
      lbe_pkg::B_LAST: if (out_free) state_next = lbe_pkg::B_IDLE;
      default: state_next = lbe_pkg::B_IDLE;
    endcase
  end

  // seen store
  always_ff @(posedge clk) begin
    if (wr_en) seen_mem[count[lbe_pkg::SEEN_AW-1:0]] <= {cur_lo, cur_hi};
    rd_data <= seen_mem[idx[lbe_pkg::SEEN_AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lbe_pkg::B_IDLE;
      count      <= '0;
      rd_v       <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= rd_issue;
      if (pop && head.kind == lbe_pkg::ENT_CLEAR) count <= '0;
      if (wr_en) count <= count + 1'b1;
      if (state == lbe_pkg::B_NEW && !hold_valid) hold_valid <= 1'b1;
      if (state == lbe_pkg::B_LAST && out_free) hold_valid <= 1'b0;
      if ((state == lbe_pkg::B_EMIT || state == lbe_pkg::B_LAST) && out_free)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_lo     <= head.lo;
      cur_hi     <= head.hi;
      cur_colour <= head.colour;
      idx        <= '0;
    end else if (rd_issue) begin
      idx <= idx + 1'b1;
    end
    if (state == lbe_pkg::B_NEW && !hold_valid) begin
      hold_lo     <= cur_lo;
      hold_hi     <= cur_hi;
      hold_colour <= cur_colour;
    end
    if ((state == lbe_pkg::B_EMIT || state == lbe_pkg::B_LAST) && out_free) begin
      out_data.site_low     <= hold_lo;
      out_data.site_high    <= hold_hi;
      out_data.bond_colour  <= hold_colour;
      out_data.last_of_cell <= (state == lbe_pkg::B_LAST);
    end
    if (state == lbe_pkg::B_EMIT && out_free) begin
      hold_lo     <= cur_lo;
      hold_hi     <= cur_hi;
      hold_colour <= cur_colour;
    end
  end

endmodule

>>> rtl/lattice_bond_enumerator.sv
// Lattice bond enumerator: each input beat names one unit cell and pass; the block returns
// the new nearest-neighbor bonds of that cell as ordered site pairs, the final one marked
// last_of_cell. A front end walks up to six candidate bonds, forms both site indices through one
// shared multiplier and queues them. A back end compares each candidate against the seen store
// one entry per cycle; the linear scan of the seen store sets the rate. The store is tracked by
// a fill count, so a restart takes effect at once and no clearing pass is needed after reset.
module lattice_bond_enumerator (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lbe_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lbe_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [10:0]   cfg_data
);

  lbe_pkg::cfg_t   cfg;
  lbe_pkg::entry_t push_data, head;
  logic            push, full, pop, empty;

  assign cfg_ready = !rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind     <= lbe_pkg::KIND_SQUARE;
      cfg.size_x   <= lbe_pkg::SIZE_W'(1);
      cfg.size_y   <= lbe_pkg::SIZE_W'(1);
      cfg.size_z   <= lbe_pkg::SIZE_W'(1);
      cfg.periodic <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbe_pkg::CFG_KIND:     cfg.kind     <= cfg_data[2:0];
        lbe_pkg::CFG_SIZE_X:   cfg.size_x   <= cfg_data;
        lbe_pkg::CFG_SIZE_Y:   cfg.size_y   <= cfg_data;
        lbe_pkg::CFG_SIZE_Z:   cfg.size_z   <= cfg_data;
        lbe_pkg::CFG_PERIODIC: cfg.periodic <= cfg_data[0];
        default:               cfg.periodic <= cfg.periodic;
      endcase
    end
  end

  lbe_front u_front (
    .clk, .rst, .cfg, .in_valid, .in_ready, .in_data,
    .push, .push_data, .full
  );

  lbe_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .head
  );

  lbe_back u_back (
    .clk, .rst, .empty, .head, .pop, .out_valid, .out_ready, .out_data
  );

endmodule

>>> rtl/lbe_checker.sv
// port-level checks on the result channel of the lattice bond enumerator
module lbe_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input lbe_pkg::out_t out_data
);

  // a stalled beat stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // bonds are ordered and never self-bonds
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.site_low < out_data.site_high)
    else $error("bond not strictly ordered");

  // colour code three never appears
  a_colour: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bond_colour != 2'd3)
    else $error("bad bond colour");

endmodule

bind lattice_bond_enumerator lbe_checker u_lbe_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data
);

>>> dv/tb.sv
// self-checking testbench for the lattice bond enumerator
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int N_RANDOM       = 170;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  lbe_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  lbe_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = lbe_pkg::CFG_KIND;
  logic [10:0]   cfg_data = '0;

  lattice_bond_enumerator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow configuration and bond store
  logic [2:0] lat_kind;
  int         len_x, len_y, len_z;
  bit         wrap_on;
  int         store_lo [lbe_pkg::MAX_BONDS];
  int         store_hi [lbe_pkg::MAX_BONDS];
  int         store_n;
  int         store_peak;

  lbe_pkg::out_t bond_q [$];
  lbe_pkg::out_t cell_bonds [$];

  int send_idle = 0;
  int recv_idle = 0;
  int n_mismatch = 0;
  int n_cells = 0;
  int n_bonds = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  function automatic longint wrap_coord(longint v, int len, bit w);
    if (len <= 0) return -1;
    if (w) return ((v % len) + len) % len;
    if (v < 0 || v >= len) return -1;
    return v;
  endfunction

  function automatic longint site2(longint x, longint y, int mult, int s);
    return (y * len_x + x) * mult + s;
  endfunction

  function automatic longint site3(longint x, longint y, longint z, int u);
    return ((x * len_y + y) * len_z + z) * 4 + u;
  endfunction

  // order the pair, drop repeats and out-of-range sites, record new ones
  function automatic void new_bond(longint a, longint b, logic [1:0] col);
    longint        lo, hi;
    lbe_pkg::out_t r;
    if (a == b) return;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (hi >= lbe_pkg::MAX_SITES) return;
    for (int n = 0; n < store_n; n++)
      if (store_lo[n] == lo && store_hi[n] == hi) return;
    if (store_n < lbe_pkg::MAX_BONDS) begin
      store_lo[store_n] = int'(lo);
      store_hi[store_n] = int'(hi);
      store_n++;
      if (store_n > store_peak) store_peak = store_n;
    end
    r.site_low = lo[9:0];
    r.site_high = hi[9:0];
    r.bond_colour = col;
    r.last_of_cell = 1'b0;
    cell_bonds = {cell_bonds, r};
  endfunction

  function automatic void pyro_cross(longint x, longint y, longint z, int ua, int ub,
                                     int dx, int dy, int dz);
    longint nx, ny, nz;
    nx = wrap_coord(x + dx, len_x, wrap_on);
    ny = wrap_coord(y + dy, len_y, wrap_on);
    nz = wrap_coord(z + dz, len_z, wrap_on);
    if (nx < 0 || ny < 0 || nz < 0) return;
    new_bond(site3(x, y, z, ua), site3(nx, ny, nz, ub), lbe_pkg::COL_X);
  endfunction

  // bonds contributed by one cell, in emission order
  function automatic void cell_bond_list(lbe_pkg::in_t c);
    longint x, y, z, nx, ny;
    x = c.cell_x;
    y = c.cell_y;
    z = c.cell_z;
    cell_bonds.delete();
    if (c.restart) store_n = 0;
    if (x >= len_x || y >= len_y) return;
    if (lat_kind == lbe_pkg::KIND_PYRO && z >= len_z) return;
    if (lat_kind < lbe_pkg::KIND_PYRO && c.pass_select) return;
    case (lat_kind)
      lbe_pkg::KIND_SQUARE: begin
        if (x + 1 < len_x)
          new_bond(site2(x, y, 1, 0), site2(x + 1, y, 1, 0), lbe_pkg::COL_X);
        else if (wrap_on && len_x > 2)
          new_bond(site2(x, y, 1, 0), site2(0, y, 1, 0), lbe_pkg::COL_X);
        if (y + 1 < len_y)
          new_bond(site2(x, y, 1, 0), site2(x, y + 1, 1, 0), lbe_pkg::COL_X);
        else if (wrap_on && len_y > 2)
          new_bond(site2(x, y, 1, 0), site2(x, 0, 1, 0), lbe_pkg::COL_X);
      end
      lbe_pkg::KIND_TRI: begin
        for (int t = 0; t < 3; t++) begin
          nx = wrap_coord(x + ((t == 0) ? 1 : (t == 1) ? 0 : -1), len_x, wrap_on);
          ny = wrap_coord(y + ((t == 0) ? 0 : 1), len_y, wrap_on);
          if (nx >= 0 && ny >= 0)
            new_bond(site2(x, y, 1, 0), site2(nx, ny, 1, 0), lbe_pkg::COL_X);
        end
      end
      lbe_pkg::KIND_HONEY: begin
        new_bond(site2(x, y, 2, 0), site2(x, y, 2, 1), lbe_pkg::COL_Z);
        nx = wrap_coord(x - 1, len_x, wrap_on);
        if (nx >= 0) new_bond(site2(x, y, 2, 0), site2(nx, y, 2, 1), lbe_pkg::COL_X);
        ny = wrap_coord(y - 1, len_y, wrap_on);
        if (ny >= 0) new_bond(site2(x, y, 2, 0), site2(x, ny, 2, 1), lbe_pkg::COL_Y);
      end
      lbe_pkg::KIND_KAGOME: begin
        new_bond(site2(x, y, 3, 0), site2(x, y, 3, 1), lbe_pkg::COL_X);
        new_bond(site2(x, y, 3, 0), site2(x, y, 3, 2), lbe_pkg::COL_X);
        new_bond(site2(x, y, 3, 1), site2(x, y, 3, 2), lbe_pkg::COL_X);
        nx = wrap_coord(x + 1, len_x, wrap_on);
        if (nx >= 0) new_bond(site2(x, y, 3, 1), site2(nx, y, 3, 0), lbe_pkg::COL_X);
        ny = wrap_coord(y + 1, len_y, wrap_on);
        if (ny >= 0) new_bond(site2(x, y, 3, 2), site2(x, ny, 3, 0), lbe_pkg::COL_X);
        nx = wrap_coord(x - 1, len_x, wrap_on);
        if (nx >= 0 && ny >= 0)
          new_bond(site2(x, y, 3, 2), site2(nx, ny, 3, 1), lbe_pkg::COL_X);
      end
      lbe_pkg::KIND_PYRO: begin
        if (!c.pass_select) begin
          for (int p = 0; p < 4; p++)
            for (int q = p + 1; q < 4; q++)
              new_bond(site3(x, y, z, p), site3(x, y, z, q), lbe_pkg::COL_X);
        end else begin
          pyro_cross(x, y, z, 0, 1, -1, 0, 0);
          pyro_cross(x, y, z, 0, 2, 0, -1, 0);
          pyro_cross(x, y, z, 0, 3, 0, 0, -1);
          pyro_cross(x, y, z, 1, 2, 0, -1, 1);
          pyro_cross(x, y, z, 1, 3, 0, 0, 0);
          pyro_cross(x, y, z, 2, 3, 0, 0, 0);
        end
      end
      default: ;
    endcase
    if (cell_bonds.size() > 0) cell_bonds[cell_bonds.size() - 1].last_of_cell = 1'b1;
  endfunction

  // one register beat; valid is dropped by the caller after the last one
  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[10:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lbe_pkg::CFG_KIND:     lat_kind = val[2:0];
      lbe_pkg::CFG_SIZE_X:   len_x = val & 11'h7ff;
      lbe_pkg::CFG_SIZE_Y:   len_y = val & 11'h7ff;
      lbe_pkg::CFG_SIZE_Z:   len_z = val & 11'h7ff;
      lbe_pkg::CFG_PERIODIC: wrap_on = val[0];
      default: ;
    endcase
    n_cfg++;
  endtask

  // wait for all bonds, then let any trailing duplicate-only scans finish
  task automatic drain();
    int pause;
    in_valid <= 1'b0;
    while (bond_q.size() != 0) @(posedge clk);
    pause = 12 * (store_peak + 8) + 100;
    repeat (pause) @(posedge clk);
    store_peak = store_n;
  endtask

  task automatic set_lattice(logic [2:0] k, int sx, int sy, int sz, bit w);
    drain();
    write_reg(lbe_pkg::CFG_KIND, k);
    write_reg(lbe_pkg::CFG_SIZE_X, sx);
    write_reg(lbe_pkg::CFG_SIZE_Y, sy);
    write_reg(lbe_pkg::CFG_SIZE_Z, sz);
    write_reg(lbe_pkg::CFG_PERIODIC, w);
    cfg_valid <= 1'b0;
  endtask

  // one cell beat; typed bonds, when given, replace the predicted ones
  task automatic send_cell(lbe_pkg::in_t c, bit typed, lbe_pkg::out_t typed_q [$]);
    int gap;
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    cell_bond_list(c);
    if (typed) cell_bonds = typed_q;
    bond_q = {bond_q, cell_bonds};
    n_cells++;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic lbe_pkg::in_t mk_cell(int x, int y, int z, bit p, bit r);
    lbe_pkg::in_t c;
    c.cell_x = x[9:0];
    c.cell_y = y[9:0];
    c.cell_z = z[9:0];
    c.pass_select = p;
    c.restart = r;
    return c;
  endfunction

  function automatic lbe_pkg::out_t mk_bond(int lo, int hi);
    lbe_pkg::out_t r;
    r.site_low = lo[9:0];
    r.site_high = hi[9:0];
    r.bond_colour = lbe_pkg::COL_X;
    r.last_of_cell = 1'b1;
    return r;
  endfunction

  // directed stimulus row
  typedef struct {
    logic [2:0] k;
    int         sx, sy, sz;
    bit         w;
    int         x, y, z;
    bit         p, r;
    int         tn;
    int         tlo, thi;
  } row_t;

  row_t rows [] = '{
    '{lbe_pkg::KIND_SQUARE, 1, 1, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 4, 1, 1, 0, 0, 0, 0, 0, 1, 1, 0, 1},
    '{lbe_pkg::KIND_SQUARE, 4, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 4, 1, 1, 1, 3, 0, 0, 0, 1, 1, 0, 3},
    '{lbe_pkg::KIND_SQUARE, 2, 2, 1, 1, 1, 1, 0, 0, 1, 0, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 4, 4, 1, 0, 4, 0, 0, 0, 1, 0, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 0, 4, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 64, 64, 1, 1, 63, 15, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 64, 64, 1, 1, 5, 20, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_SQUARE, 1024, 1, 1, 1, 1023, 0, 0, 0, 1, 1, 0, 1023},
    '{lbe_pkg::KIND_SQUARE, 1, 1024, 1, 1, 0, 1023, 0, 0, 1, 1, 0, 1023},
    '{lbe_pkg::KIND_TRI, 3, 3, 1, 1, 0, 0, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_TRI, 3, 3, 1, 1, 1, 1, 0, 1, 0, 0, 0, 0},
    '{lbe_pkg::KIND_HONEY, 3, 3, 1, 1, 0, 0, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_HONEY, 3, 3, 1, 0, 2, 2, 0, 0, 0, -1, 0, 0},
    '{lbe_pkg::KIND_KAGOME, 3, 3, 1, 1, 1, 1, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_KAGOME, 3, 3, 1, 0, 0, 0, 0, 0, 0, -1, 0, 0},
    '{lbe_pkg::KIND_PYRO, 2, 2, 2, 1, 1, 1, 1, 1, 1, -1, 0, 0},
    '{lbe_pkg::KIND_PYRO, 2, 2, 2, 1, 0, 0, 0, 0, 1, -1, 0, 0},
    '{lbe_pkg::KIND_PYRO, 2, 2, 2, 1, 0, 0, 0, 1, 0, -1, 0, 0},
    '{lbe_pkg::KIND_PYRO, 2, 2, 2, 1, 0, 0, 2, 0, 0, 0, 0, 0},
    '{lbe_pkg::KIND_PYRO, 1, 1, 1024, 0, 0, 0, 1023, 0, 1, 0, 0, 0},
    '{3'd5, 4, 4, 4, 1, 0, 0, 0, 0, 1, 0, 0, 0},
    '{3'd7, 4, 4, 4, 1, 1, 1, 1, 1, 1, 0, 0, 0}
  };

  // random lattice and a walk over its cells in loop order
  task automatic random_phase(ref int done);
    logic [2:0] k;
    int sx, sy, sz, steps, cx, cy, cz;
    bit w;
    lbe_pkg::out_t none [$];
    k = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    sx = ($urandom_range(9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 6);
    sy = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
    sz = ($urandom_range(9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 4);
    w = $urandom_range(1);
    set_lattice(k, sx, sy, sz, w);
    steps = $urandom_range(10, 30);
    cx = $urandom_range(sx - 1);
    cy = $urandom_range(sy - 1);
    cz = (k == lbe_pkg::KIND_PYRO) ? $urandom_range(sz - 1) : 0;
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(99) < 15) begin
        send_cell(mk_cell($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(1), $urandom_range(7) == 0), 1'b0, none);
      end else begin
        send_cell(mk_cell(cx, cy, cz, 1'b0, i == 0 || $urandom_range(29) == 0), 1'b0, none);
        if (k == lbe_pkg::KIND_PYRO && $urandom_range(3) != 0)
          send_cell(mk_cell(cx, cy, cz, 1'b1, 1'b0), 1'b0, none);
        done++;
        // pyrochlore walks z fastest, planar kinds walk x fastest
        if (k == lbe_pkg::KIND_PYRO) begin
          cz++;
          if (cz >= sz) begin cz = 0; cy++; end
          if (cy >= sy) begin cy = 0; cx++; end
          if (cx >= sx) cx = 0;
        end else begin
          cx++;
          if (cx >= sx) begin cx = 0; cy++; end
          if (cy >= sy) cy = 0;
        end
      end
    end
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    lbe_pkg::out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        n_bonds++;
        if (bond_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected bond %0d-%0d", out_data.site_low, out_data.site_high);
        end else begin
          want = bond_q.pop_front();
          if (out_data !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("bond mismatch: want %0d-%0d col %0d last %0b, got %0d-%0d col %0d last %0b",
                       want.site_low, want.site_high, want.bond_colour, want.last_of_cell,
                       out_data.site_low, out_data.site_high, out_data.bond_colour,
                       out_data.last_of_cell);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int done;
    lbe_pkg::out_t typed_q [$];
    lat_kind = lbe_pkg::KIND_SQUARE;
    len_x = 1;
    len_y = 1;
    len_z = 1;
    wrap_on = 1'b0;
    store_n = 0;
    store_peak = 0;
    done = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (rows[i]) begin
      if (i > 0 && (rows[i].k != lat_kind || rows[i].sx != len_x || rows[i].sy != len_y ||
                    rows[i].sz != len_z || rows[i].w != wrap_on))
        set_lattice(rows[i].k, rows[i].sx, rows[i].sy, rows[i].sz, rows[i].w);
      typed_q.delete();
      if (rows[i].tn == 1) typed_q = {typed_q, mk_bond(rows[i].tlo, rows[i].thi)};
      send_cell(mk_cell(rows[i].x, rows[i].y, rows[i].z, rows[i].p, rows[i].r),
                rows[i].tn >= 0, typed_q);
    end

    // random phases under three stall mixes
    send_idle = 22;
    recv_idle = 67;
    while (done < N_RANDOM) begin
      if (done >= 2 * N_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (done >= N_RANDOM / 3) begin
        send_idle = 67;
        recv_idle = 22;
      end
      random_phase(done);
    end

    drain();
    $display("covered %0d cells, %0d bonds and %0d register writes over all lattice kinds",
             n_cells, n_bonds, n_cfg);
    $display("mismatches: %0d, bonds still pending: %0d", n_mismatch, bond_q.size());
    if (n_mismatch == 0 && bond_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> lattice_bond_enumerator.f
rtl/lbe_pkg.sv
rtl/lbe_front.sv
rtl/lbe_queue.sv
rtl/lbe_back.sv
rtl/lattice_bond_enumerator.sv
rtl/lbe_checker.sv
dv/tb.sv
